>>> src/vnt_pkg.sv
// Package for the value-noise turbulence texel block.
// Payload structs, register indexes, operation codes and config helpers.
// Depends on nothing; used by value_noise_turbulence_texel.
`timescale 1ns / 1ps

package vnt_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned MaxWidthDef   = 256;
  localparam int unsigned MaxHeightDef  = 256;
  localparam int unsigned MaxLog2Def    = 7;

  // Fixed field widths
  localparam int unsigned CoordW  = 8;
  localparam int unsigned NoiseW  = 16;
  localparam int unsigned IntensW = 12;
  localparam int unsigned DimW    = 9;
  localparam int unsigned Log2W   = 3;
  localparam int unsigned CfgIdxW = 2;

  // Largest start exponent the register can hold
  localparam int unsigned Log2CfgMax = (1 << Log2W) - 1;

  // Reset values of the registers
  localparam logic [DimW-1:0]  WidthRst  = 9'd256;
  localparam logic [DimW-1:0]  HeightRst = 9'd256;
  localparam logic [Log2W-1:0] Log2Rst   = 3'd6;

  typedef enum logic [CfgIdxW-1:0] {
    CfgImageWidth  = 2'd0,
    CfgImageHeight = 2'd1,
    CfgLog2Start   = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    FuncWrite = 1'b0,
    FuncTurb  = 1'b1
  } func_e;

  typedef struct packed {
    logic              func;
    logic [CoordW-1:0] x_coord;
    logic [CoordW-1:0] y_coord;
    logic [NoiseW-1:0] noise_sample;
  } in_item_t;

  typedef struct packed {
    logic [IntensW-1:0] intensity;
    logic               range_error;
  } out_item_t;

  // Zero reads as one, anything above the limit saturates
  function automatic logic [DimW-1:0] eff_dim(logic [DimW-1:0] v, int unsigned lim);
    logic [DimW-1:0] r;
    if (v == '0) begin
      r = DimW'(1);
    end else if (int'(v) > int'(lim)) begin
      r = DimW'(lim);
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic [Log2W-1:0] sat_log2(logic [Log2W-1:0] v, int unsigned lim);
    logic [Log2W-1:0] r;
    if (int'(v) > int'(lim)) begin
      r = Log2W'(lim);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

>>> src/value_noise_turbulence_texel.sv
// Value-noise turbulence texel engine: noise table, octave loop, accumulator.
// Depends on vnt_pkg for payload structs, codes and config helpers.
`timescale 1ns / 1ps

// Usage
//   Input channel (in_valid_i / in_ready_o / in_data_i) takes one item per
//   transfer. func = write stores noise_sample at (x,y); func = turbulence
//   sums the octaves of smoothed noise at (x,y). Every item gives exactly one
//   transfer on the output channel (out_valid_o / out_ready_i / out_data_o).
//   A coordinate at or beyond the configured width or height writes nothing
//   and returns range_error = 1 with intensity 0.
//   Config channel (cfg_*) is always ready; write only while the block is idle.
// Timing
//   Write and error items: the result is registered from StFin as soon as
//   the output register is free. Turbulence: L+1 octaves issue one per cycle
//   (L = effective start exponent), then read, two multiply stages and the
//   accumulate drain; the result is registered from StFin once the last
//   octave is accumulated and the output register is free. Four neighbor
//   reads per octave come from two identical dual-read noise tables. The
//   next item is taken once the previous result sits in the output register.
// Reset
//   Control, config and output valid clear; 256 x 256, start exponent 6.
//   Table contents are undefined until written.
// Stall
//   A held output keeps its data; a finished item waits until it frees up.

module value_noise_turbulence_texel #(
  parameter int unsigned MAX_WIDTH     = vnt_pkg::MaxWidthDef,
  parameter int unsigned MAX_HEIGHT    = vnt_pkg::MaxHeightDef,
  parameter int unsigned MAX_LOG2_SIZE = vnt_pkg::MaxLog2Def
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  vnt_pkg::in_item_t                in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output vnt_pkg::out_item_t               out_data_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [vnt_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [vnt_pkg::DimW-1:0]         cfg_data_i
);

  localparam int unsigned Depth = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AW    = $clog2(Depth);
  // Largest exponent that can actually occur
  localparam int unsigned Eml   = (MAX_LOG2_SIZE < vnt_pkg::Log2CfgMax) ?
                                  MAX_LOG2_SIZE : vnt_pkg::Log2CfgMax;
  localparam int unsigned WW    = Eml + 1;                 // weight, up to s
  localparam int unsigned AXW   = vnt_pkg::NoiseW + Eml;   // one-axis blend
  localparam int unsigned TW    = vnt_pkg::NoiseW + 2*Eml; // octave term
  localparam int unsigned AccW  = vnt_pkg::NoiseW + 1 + 2*Eml;
  localparam int unsigned CW    = vnt_pkg::CoordW;
  localparam int unsigned NW    = vnt_pkg::NoiseW;
  localparam int unsigned LW    = vnt_pkg::Log2W;

  typedef enum logic [1:0] {
    StIdle,
    StRun,
    StFin
  } state_e;

  function automatic logic [AW-1:0] addr_of(logic [CW-1:0] cx, logic [CW-1:0] cy);
    return AW'(cy) * AW'(MAX_WIDTH) + AW'(cx);
  endfunction

  // ---------------------------------------------------------------------
  // Configuration, stored already clamped
  // ---------------------------------------------------------------------
  logic [vnt_pkg::DimW-1:0] width_q, height_q;
  logic [LW-1:0]            lg_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= vnt_pkg::eff_dim(vnt_pkg::WidthRst, MAX_WIDTH);
      height_q <= vnt_pkg::eff_dim(vnt_pkg::HeightRst, MAX_HEIGHT);
      lg_q     <= vnt_pkg::sat_log2(vnt_pkg::Log2Rst, MAX_LOG2_SIZE);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        vnt_pkg::CfgImageWidth:  width_q  <= vnt_pkg::eff_dim(cfg_data_i, MAX_WIDTH);
        vnt_pkg::CfgImageHeight: height_q <= vnt_pkg::eff_dim(cfg_data_i, MAX_HEIGHT);
        vnt_pkg::CfgLog2Start:   lg_q     <= vnt_pkg::sat_log2(cfg_data_i[LW-1:0],
                                                               MAX_LOG2_SIZE);
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Input transfer and range check
  // ---------------------------------------------------------------------
  state_e state_q;
  logic   accept, in_range, is_turb, mem_we;
  logic [AW-1:0] waddr;

  assign in_ready_o = (state_q == StIdle);
  assign accept     = in_valid_i && in_ready_o;
  assign in_range   = ({1'b0, in_data_i.x_coord} < width_q) &&
                      ({1'b0, in_data_i.y_coord} < height_q);
  assign is_turb    = (in_data_i.func == vnt_pkg::FuncTurb);
  assign mem_we     = accept && in_range && (in_data_i.func == vnt_pkg::FuncWrite);
  assign waddr      = addr_of(in_data_i.x_coord, in_data_i.y_coord);

  // ---------------------------------------------------------------------
  // Octave issue: one octave (four neighbor reads) per cycle
  // ---------------------------------------------------------------------
  logic [CW-1:0] x_q, y_q;
  logic [LW-1:0] k_q;
  logic          issue_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      issue_q <= 1'b0;
      k_q     <= '0;
    end else if (accept && in_range && is_turb) begin
      issue_q <= 1'b1;
      k_q     <= '0;
    end else if (issue_q) begin
      if (k_q == lg_q) begin
        issue_q <= 1'b0;
      end else begin
        k_q <= k_q + LW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_q <= in_data_i.x_coord;
      y_q <= in_data_i.y_coord;
    end
  end

  // Cell at (x>>k, y>>k) is inside the table since x < width; the
  // left/up neighbor wraps to the last column or row.
  logic [CW-1:0] x1, y1, x2, y2;
  logic [AW-1:0] ra11, ra21, ra12, ra22;
  logic [WW-1:0] fx_iss, fy_iss;

  assign x1 = x_q >> k_q;
  assign y1 = y_q >> k_q;
  assign x2 = (x1 == '0) ? CW'(width_q - vnt_pkg::DimW'(1))  : x1 - CW'(1);
  assign y2 = (y1 == '0) ? CW'(height_q - vnt_pkg::DimW'(1)) : y1 - CW'(1);
  assign ra11 = addr_of(x1, y1);
  assign ra21 = addr_of(x2, y1);
  assign ra12 = addr_of(x1, y2);
  assign ra22 = addr_of(x2, y2);
  assign fx_iss = WW'(x_q & ~({CW{1'b1}} << k_q));
  assign fy_iss = WW'(y_q & ~({CW{1'b1}} << k_q));

  // ---------------------------------------------------------------------
  // Noise tables: two identical copies, each read at two addresses.
  // Copy A serves the lower row, copy B the upper row.
  // ---------------------------------------------------------------------
  logic [NW-1:0] mem_a [Depth];
  logic [NW-1:0] mem_b [Depth];
  logic [NW-1:0] n11_q, n21_q, n12_q, n22_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_a[waddr] <= in_data_i.noise_sample;
    end
    n11_q <= mem_a[ra11];
    n21_q <= mem_a[ra21];
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_b[waddr] <= in_data_i.noise_sample;
    end
    n12_q <= mem_b[ra12];
    n22_q <= mem_b[ra22];
  end

  // ---------------------------------------------------------------------
  // Blend pipeline: horizontal blend, vertical blend, accumulate
  // ---------------------------------------------------------------------
  logic          v1_q, v2_q, v3_q;
  logic [LW-1:0] k1_q, k2_q, k3_q;
  logic [WW-1:0] fx1_q, fy1_q, fy2_q;
  logic [AXW-1:0] a_q, b_q, a_d, b_d;
  logic [TW-1:0]  t_q, t_d;
  logic [AccW-1:0] acc_q, acc_d;
  logic [WW-1:0]  s1, s2;
  logic [LW-1:0]  sh;
  logic           last;

  assign s1  = WW'(1) << k1_q;
  assign a_d = AXW'(fx1_q) * AXW'(n11_q) + AXW'(s1 - fx1_q) * AXW'(n21_q);
  assign b_d = AXW'(fx1_q) * AXW'(n12_q) + AXW'(s1 - fx1_q) * AXW'(n22_q);

  assign s2  = WW'(1) << k2_q;
  assign t_d = TW'(fy2_q) * TW'(a_q) + TW'(s2 - fy2_q) * TW'(b_q);

  assign sh    = lg_q - k3_q;
  assign acc_d = acc_q + (AccW'(t_q) << sh);
  assign last  = v3_q && (k3_q == lg_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= issue_q;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    k1_q  <= k_q;
    fx1_q <= fx_iss;
    fy1_q <= fy_iss;
    k2_q  <= k1_q;
    fy2_q <= fy1_q;
    a_q   <= a_d;
    b_q   <= b_d;
    k3_q  <= k2_q;
    t_q   <= t_d;
    if (accept) begin
      acc_q <= '0;
    end else if (v3_q) begin
      acc_q <= acc_d;
    end
  end

  // Final scale: 128 * sum / 2^L over Q4.12 and two weight factors
  logic [4:0]                   shr;
  logic [vnt_pkg::IntensW-1:0]  intens_val;

  assign shr        = {1'b0, lg_q, 1'b0} + 5'd5;
  assign intens_val = vnt_pkg::IntensW'(acc_q >> shr);

  // ---------------------------------------------------------------------
  // Control and output register
  // ---------------------------------------------------------------------
  logic               out_valid_q;
  vnt_pkg::out_item_t out_data_q;
  logic               res_err_q, res_turb_q;
  logic               load_out;

  // Output register takes a finished item when it is empty or being drained
  assign load_out = (state_q == StFin) && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
      res_err_q   <= 1'b0;
      res_turb_q  <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (accept) begin
            res_err_q  <= !in_range;
            res_turb_q <= in_range && is_turb;
            state_q    <= (in_range && is_turb) ? StRun : StFin;
          end
        end
        StRun: begin
          if (last) begin
            state_q <= StFin;
          end
        end
        StFin: begin
          if (load_out) begin
            out_data_q.intensity   <= res_turb_q ? intens_val : '0;
            out_data_q.range_error <= res_err_q;
            state_q                <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

>>> test/tb_top.sv
// Self-checking testbench for value_noise_turbulence_texel.
// Drives noise-table writes and turbulence lookups through a directed table and then
// random phases, and predicts every result in SV. Depends on vnt_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_top;

  // Cycles without any transfer before the run is declared hung. The slowest
  // item is an eight-octave lookup plus random sender gaps and receiver stalls.
  localparam int unsigned IdleLimit   = 5000;
  localparam int unsigned PhaseItems  = 150;
  localparam int unsigned NumPhases   = 12;
  localparam int unsigned TableSize   = vnt_pkg::MaxWidthDef * vnt_pkg::MaxHeightDef;

  // ---------------------------------------------------------------------------
  // DUT signals. Every input has a known value from time zero.
  // ---------------------------------------------------------------------------
  logic                        clk_i       = 1'b0;
  logic                        rst_ni      = 1'b0;
  logic                        in_valid_i  = 1'b0;
  logic                        in_ready_o;
  vnt_pkg::in_item_t           in_data_i   = '0;
  logic                        out_valid_o;
  logic                        out_ready_i = 1'b0;
  vnt_pkg::out_item_t          out_data_o;
  logic                        cfg_valid_i = 1'b0;
  logic                        cfg_ready_o;
  logic [vnt_pkg::CfgIdxW-1:0] cfg_index_i = '0;
  logic [vnt_pkg::DimW-1:0]    cfg_data_i  = '0;

  value_noise_turbulence_texel uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // ---------------------------------------------------------------------------
  // Shadow state of the block: registers plus the noise table. The written
  // map keeps the stimulus away from table entries that were never loaded.
  // ---------------------------------------------------------------------------
  logic [vnt_pkg::DimW-1:0]   img_w    = vnt_pkg::WidthRst;
  logic [vnt_pkg::DimW-1:0]   img_h    = vnt_pkg::HeightRst;
  logic [vnt_pkg::Log2W-1:0]  start_lg = vnt_pkg::Log2Rst;
  logic [vnt_pkg::NoiseW-1:0] noise_mem [TableSize];
  bit                         written   [TableSize];

  vnt_pkg::out_item_t pending_results [$];
  int unsigned n_sent      = 0;
  int unsigned n_errors    = 0;
  int unsigned idle_cycles = 0;

  // Idle percentages for the current phase (0 = never idles)
  int unsigned snd_pct = 0;
  int unsigned rcv_pct = 0;

  // Directed stimulus: a register write or an item, with the result typed in
  // only where it is obvious from the table contents.
  typedef struct {
    bit                       is_cfg;
    vnt_pkg::cfg_idx_e        idx;
    logic [vnt_pkg::DimW-1:0] val;
    vnt_pkg::in_item_t        it;
    bit                       typed;
    vnt_pkg::out_item_t       res;
  } dir_row_t;

  dir_row_t dir_tab [$];

  // ---------------------------------------------------------------------------
  // Clock, 20 ns period
  // ---------------------------------------------------------------------------
  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Receiver: ready is redrawn every cycle according to the phase
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= rcv_pct);
  end

  // Zero reads as one, anything past the table size saturates
  function automatic int unsigned clamp_dim(logic [vnt_pkg::DimW-1:0] v, int unsigned lim);
    if (v == '0) return 1;
    if (int'(v) > int'(lim)) return lim;
    return int'(v);
  endfunction

  // Applies one accepted item to the shadow table and returns its result.
  // Octave sum is kept exact in 64 bits; only the final shift truncates.
  function automatic vnt_pkg::out_item_t texel_predict(vnt_pkg::in_item_t it);
    int unsigned w, h, lg, s, fx, fy, x1, y1, x2, y2;
    longint unsigned acc, term;
    vnt_pkg::out_item_t r;
    w   = clamp_dim(img_w, vnt_pkg::MaxWidthDef);
    h   = clamp_dim(img_h, vnt_pkg::MaxHeightDef);
    lg  = (int'(start_lg) > int'(vnt_pkg::MaxLog2Def)) ? vnt_pkg::MaxLog2Def : start_lg;
    r   = '0;
    acc = 0;
    if (it.x_coord >= w || it.y_coord >= h) begin
      r.range_error = 1'b1;
    end else if (it.func == vnt_pkg::FuncWrite) begin
      noise_mem[{it.y_coord, it.x_coord}] = it.noise_sample;
      written[{it.y_coord, it.x_coord}]   = 1'b1;
    end else begin
      for (int unsigned k = 0; k <= lg; k++) begin
        s  = 1 << k;
        fx = it.x_coord & (s - 1);
        fy = it.y_coord & (s - 1);
        x1 = (it.x_coord >> k) % w;
        y1 = (it.y_coord >> k) % h;
        // left/up neighbor wraps at the configured size
        x2 = (x1 + w - 1) % w;
        y2 = (y1 + h - 1) % h;
        term = longint'(fx * fy) * noise_mem[{y1[7:0], x1[7:0]}]
             + longint'((s - fx) * fy) * noise_mem[{y1[7:0], x2[7:0]}]
             + longint'(fx * (s - fy)) * noise_mem[{y2[7:0], x1[7:0]}]
             + longint'((s - fx) * (s - fy)) * noise_mem[{y2[7:0], x2[7:0]}];
        acc += term << (lg - k);
      end
      r.intensity = vnt_pkg::IntensW'(acc >> (2 * lg + 5));
    end
    return r;
  endfunction

  function automatic vnt_pkg::in_item_t mk_item(vnt_pkg::func_e f, int unsigned x,
                                                int unsigned y, int unsigned smp);
    vnt_pkg::in_item_t it;
    it.func         = f;
    it.x_coord      = vnt_pkg::CoordW'(x);
    it.y_coord      = vnt_pkg::CoordW'(y);
    it.noise_sample = vnt_pkg::NoiseW'(smp);
    return it;
  endfunction

  function automatic void add_cfg(vnt_pkg::cfg_idx_e idx, int unsigned val);
    dir_row_t row;
    row        = '{is_cfg: 1'b0, idx: vnt_pkg::CfgImageWidth, val: '0, it: '0,
                   typed: 1'b0, res: '0};
    row.is_cfg = 1'b1;
    row.idx    = idx;
    row.val    = vnt_pkg::DimW'(val);
    dir_tab.push_back(row);
  endfunction

  function automatic void add_item(vnt_pkg::func_e f, int unsigned x, int unsigned y,
                                   int unsigned smp, bit typed,
                                   int unsigned intens, bit err);
    dir_row_t row;
    row                 = '{is_cfg: 1'b0, idx: vnt_pkg::CfgImageWidth, val: '0, it: '0,
                            typed: 1'b0, res: '0};
    row.it              = mk_item(f, x, y, smp);
    row.typed           = typed;
    row.res.intensity   = vnt_pkg::IntensW'(intens);
    row.res.range_error = err;
    dir_tab.push_back(row);
  endfunction

  // ---------------------------------------------------------------------------
  // Input side. Valid is raised once and stays up until the transfer; the
  // caller lowers it only when it idles or waits.
  // ---------------------------------------------------------------------------
  task automatic send_item(input vnt_pkg::in_item_t it, input bit typed,
                           input vnt_pkg::out_item_t typed_res);
    vnt_pkg::out_item_t res;
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    res = texel_predict(it);
    if (typed) res = typed_res;
    pending_results.push_back(res);
    n_sent++;
  endtask

  task automatic issue(input vnt_pkg::in_item_t it);
    while ($urandom_range(99) < snd_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    send_item(it, 1'b0, '0);
  endtask

  // Hold the input off until every outstanding result has come back
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  // Register write; valid drops only after the last write of a group
  task automatic cfg_write(input vnt_pkg::cfg_idx_e idx,
                           input logic [vnt_pkg::DimW-1:0] val, input bit last);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      vnt_pkg::CfgImageWidth: begin
        img_w = val;
      end
      vnt_pkg::CfgImageHeight: begin
        img_h = val;
      end
      default: begin
        start_lg = val[vnt_pkg::Log2W-1:0];
      end
    endcase
    if (last) cfg_valid_i <= 1'b0;
  endtask

  task automatic set_config(input int unsigned w, input int unsigned h, input int unsigned lg);
    drain();
    cfg_write(vnt_pkg::CfgImageWidth, vnt_pkg::DimW'(w), 1'b0);
    cfg_write(vnt_pkg::CfgImageHeight, vnt_pkg::DimW'(h), 1'b0);
    cfg_write(vnt_pkg::CfgLog2Start, vnt_pkg::DimW'(lg), 1'b1);
  endtask

  // Load every table cell that a lookup at (x,y) will touch and that has no
  // value yet, so the block never reads an unloaded entry.
  task automatic prime_cells(input int unsigned x, input int unsigned y);
    int unsigned w, h, x1, y1;
    int unsigned cx [2];
    int unsigned cy [2];
    w = clamp_dim(img_w, vnt_pkg::MaxWidthDef);
    h = clamp_dim(img_h, vnt_pkg::MaxHeightDef);
    for (int unsigned k = 0; k <= start_lg; k++) begin
      x1 = (x >> k) % w;
      y1 = (y >> k) % h;
      cx[0] = x1;
      cx[1] = (x1 + w - 1) % w;
      cy[0] = y1;
      cy[1] = (y1 + h - 1) % h;
      for (int i = 0; i < 2; i++) begin
        for (int j = 0; j < 2; j++) begin
          if (!written[{cy[j][7:0], cx[i][7:0]}]) begin
            issue(mk_item(vnt_pkg::FuncWrite, cx[i], cy[j], $urandom_range(0, 65535)));
          end
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Output side: every result transfer is matched against the oldest
  // prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    vnt_pkg::out_item_t exp_res;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: intensity %0d range_error %0d",
               out_data_o.intensity, out_data_o.range_error);
        n_errors++;
      end else begin
        exp_res = pending_results.pop_front();
        if (out_data_o.intensity !== exp_res.intensity) begin
          $error("intensity: expected %0d, got %0d", exp_res.intensity,
                 out_data_o.intensity);
          n_errors++;
        end
        if (out_data_o.range_error !== exp_res.range_error) begin
          $error("range_error: expected %0d, got %0d", exp_res.range_error,
                 out_data_o.range_error);
          n_errors++;
        end
      end
    end
  end

  // Watchdog: cycles in a row with no transfer on any channel
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    wait (idle_cycles >= IdleLimit);
    $display("tb_top: FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned w, h, x, y, r, sel, smp;

    // Directed table. Starts at reset settings: 256 x 256, start exponent 6.
    // In-range writes always answer zero with no error.
    add_item(vnt_pkg::FuncWrite, 0, 0, 16'hFFFF, 1, 0, 0);
    add_item(vnt_pkg::FuncWrite, 255, 255, 16'h0000, 1, 0, 0);
    add_item(vnt_pkg::FuncWrite, 255, 0, 16'hFFFF, 1, 0, 0);
    add_item(vnt_pkg::FuncWrite, 0, 255, 16'hFFFF, 1, 0, 0);
    // zero fraction at every octave: all weight lands on (255,255), which is 0
    add_item(vnt_pkg::FuncTurb, 0, 0, 16'h0000, 1, 0, 0);
    add_item(vnt_pkg::FuncWrite, 128, 64, 16'h8001, 1, 0, 0);
    // zero width and height act as 1: only (0,0) is inside
    add_cfg(vnt_pkg::CfgImageWidth, 0);
    add_cfg(vnt_pkg::CfgImageHeight, 0);
    add_item(vnt_pkg::FuncWrite, 1, 0, 16'h1234, 1, 0, 1);
    add_item(vnt_pkg::FuncTurb, 0, 1, 16'h0000, 1, 0, 1);
    add_item(vnt_pkg::FuncTurb, 255, 255, 16'hFFFF, 1, 0, 1);
    // 1x1 table holding 0xFFFF: a single octave gives 0xFFFF >> 5
    add_cfg(vnt_pkg::CfgLog2Start, 0);
    add_item(vnt_pkg::FuncTurb, 0, 0, 16'h0000, 1, 2047, 0);
    // eight octaves: 0xFFFF * 255 >> 12, the largest value reachable
    add_cfg(vnt_pkg::CfgLog2Start, 7);
    add_item(vnt_pkg::FuncTurb, 0, 0, 16'h0000, 1, 4079, 0);
    add_item(vnt_pkg::FuncWrite, 0, 0, 16'h0000, 1, 0, 0);
    add_item(vnt_pkg::FuncTurb, 0, 0, 16'hFFFF, 1, 0, 0);
    // oversized width saturates to the full table
    add_cfg(vnt_pkg::CfgImageWidth, 511);
    add_cfg(vnt_pkg::CfgImageHeight, 256);
    add_item(vnt_pkg::FuncWrite, 0, 0, 16'hFFFF, 1, 0, 0);
    add_item(vnt_pkg::FuncTurb, 0, 0, 16'h0000, 1, 0, 0);
    add_item(vnt_pkg::FuncWrite, 1, 1, 16'h7FFE, 1, 0, 0);
    add_item(vnt_pkg::FuncWrite, 0, 1, 16'h0F0F, 1, 0, 0);
    add_item(vnt_pkg::FuncWrite, 1, 0, 16'hF0F0, 1, 0, 0);
    add_item(vnt_pkg::FuncTurb, 1, 1, 16'h0000, 0, 0, 0);

    for (int i = 0; i < TableSize; i++) written[i] = 1'b0;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_cfg) begin
        if (i == 0 || !dir_tab[i-1].is_cfg) drain();
        cfg_write(dir_tab[i].idx, dir_tab[i].val,
                  (i + 1 == dir_tab.size()) || !dir_tab[i+1].is_cfg);
      end else begin
        send_item(dir_tab[i].it, dir_tab[i].typed, dir_tab[i].res);
      end
    end

    // Random phases. Idle pattern cycles through: none, sender, receiver, both.
    for (int unsigned p = 0; p < NumPhases; p++) begin
      case (p)
        0: begin
          set_config(256, 256, 7);
        end
        1: begin
          set_config(1, 1, 0);
        end
        2: begin
          set_config(511, 511, 3);
        end
        3: begin
          set_config(3, 200, 5);
        end
        default: begin
          // mostly small tables so the lookups stay cheap to prime
          r = $urandom_range(99);
          w = (r < 70) ? $urandom_range(1, 16) :
              (r < 90) ? $urandom_range(17, 256) : $urandom_range(0, 511);
          r = $urandom_range(99);
          h = (r < 70) ? $urandom_range(1, 16) :
              (r < 90) ? $urandom_range(17, 256) : $urandom_range(0, 511);
          set_config(w, h, $urandom_range(0, 7));
        end
      endcase
      case (p % 4)
        0: begin
          snd_pct = 0;
          rcv_pct = 0;
        end
        1: begin
          snd_pct = 52;
          rcv_pct = 0;
        end
        2: begin
          snd_pct = 0;
          rcv_pct = 52;
        end
        default: begin
          snd_pct = 24;
          rcv_pct = 24;
        end
      endcase

      w = clamp_dim(img_w, vnt_pkg::MaxWidthDef);
      h = clamp_dim(img_h, vnt_pkg::MaxHeightDef);
      r = n_sent + PhaseItems;
      while (n_sent < r) begin
        // occasionally let the block run completely dry
        if ($urandom_range(99) == 0) drain();
        smp = $urandom_range(99) < 10 ? ($urandom_range(1) ? 16'hFFFF : 16'h0000)
                                      : $urandom_range(0, 65535);
        sel = $urandom_range(99);
        if (sel < 15) begin
          // off-image coordinate, either operation
          if (w < 256 && (h == 256 || $urandom_range(1))) begin
            x = $urandom_range(w, 255);
            y = $urandom_range(0, 255);
          end else if (h < 256) begin
            x = $urandom_range(0, 255);
            y = $urandom_range(h, 255);
          end else begin
            // full table: nothing is off-image, so the lookup needs its cells
            x = $urandom_range(0, w - 1);
            y = $urandom_range(0, h - 1);
            prime_cells(x, y);
          end
          issue(mk_item(vnt_pkg::func_e'($urandom_range(1)), x, y, smp));
        end else if (sel < 45) begin
          issue(mk_item(vnt_pkg::FuncWrite, $urandom_range(0, w - 1),
                        $urandom_range(0, h - 1), smp));
        end else begin
          x = $urandom_range(0, w - 1);
          y = $urandom_range(0, h - 1);
          prime_cells(x, y);
          issue(mk_item(vnt_pkg::FuncTurb, x, y, smp));
        end
      end
    end

    drain();
    rcv_pct = 0;
    // any late or extra result shows up in this window
    repeat (24) @(posedge clk_i);

    if (n_errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
